>>> sv/tti_pkg.sv
`timescale 1ns / 1ps
package tti_pkg;

  // field widths
  localparam int unsigned RAW_W    = 12;
  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned REGION_W = 2;

  // reset value of the entry count register
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // product of a raw difference (12 bits) and a temperature difference (17 bits signed)
  localparam int unsigned PROD_W    = 30;
  // largest product magnitude is 4095 * 65535, which fits in 28 bits
  localparam int unsigned MAG_W     = 28;
  localparam int unsigned DIV_CNT_W = $clog2(MAG_W);

  // request codes
  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_CONVERT = 1'b1;

  // result region codes
  localparam logic [REGION_W-1:0] REGION_INTERP = 2'd0;
  localparam logic [REGION_W-1:0] REGION_ABOVE  = 2'd1;
  localparam logic [REGION_W-1:0] REGION_BELOW  = 2'd2;

  // one calibration point
  typedef struct packed {
    logic [RAW_W-1:0]  raw;
    logic [TEMP_W-1:0] temp;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // divider control
  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [RAW_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> sv/tti_in_if.sv
`timescale 1ns / 1ps
interface tti_in_if import tti_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [IDX_W-1:0]         entry_index;
  logic [RAW_W-1:0]         entry_raw;
  logic signed [TEMP_W-1:0] entry_temp;
  logic [RAW_W-1:0]         sample_raw;

  modport source (
    output valid, func, entry_index, entry_raw, entry_temp, sample_raw,
    input  ready
  );

  modport sink (
    input  valid, func, entry_index, entry_raw, entry_temp, sample_raw,
    output ready
  );
endinterface

>>> sv/tti_out_if.sv
`timescale 1ns / 1ps
interface tti_out_if import tti_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic [REGION_W-1:0]      region;

  modport source (
    output valid, temperature, region,
    input  ready
  );

  modport sink (
    input  valid, temperature, region,
    output ready
  );
endinterface

>>> sv/tti_ram.sv
`timescale 1ns / 1ps
module tti_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/tti_div.sv
`timescale 1ns / 1ps
module tti_div import tti_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [MAG_W-1:0]     quo_q;
  logic [RAW_W-1:0]     rem_q;
  logic [RAW_W-1:0]     den_q;

  logic [RAW_W:0]   rem_sh;
  logic [RAW_W+1:0] diff;
  logic             ge;
  logic [RAW_W-1:0] rem_n;

  // one restoring shift-subtract step
  always_comb begin
    rem_sh = {rem_q, quo_q[MAG_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    ge     = ~diff[RAW_W+1];
    rem_n  = ge ? diff[RAW_W-1:0] : rem_sh[RAW_W-1:0];
  end

  // step sequencer, one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(MAG_W - 1);
        quo_q  <= req_i.dividend;
        den_q  <= req_i.divisor;
        rem_q  <= '0;
      end else if (busy_q) begin
        quo_q <= {quo_q[MAG_W-2:0], ge};
        rem_q <= rem_n;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> sv/thermistor_table_interpolator.sv
`timescale 1ns / 1ps
// Thermistor ADC to temperature (tenths of a degree) by piecewise linear interpolation over a
// calibration table of descending raw points held in a small RAM. A write request stores
// one point and gives no result. A convert request reads entry 0 and the last entry in use,
// then scans one entry per cycle through the RAM read port for the segment that holds the
// reading, multiplies once and divides with a 28-step shift-subtract divider. One request is
// in flight at a time; ready returns once the result has been taken.
module thermistor_table_interpolator import tti_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  tti_in_if.sink           in_i,
  tti_out_if.source        out_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned IW = (AW > IDX_W) ? AW : IDX_W;
  localparam int unsigned CW = ($clog2(TABLE_DEPTH + 1) > CFG_W) ?
                               $clog2(TABLE_DEPTH + 1) : CFG_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_BOT,
    S_SCAN,
    S_MUL,
    S_DIVS,
    S_DIVW,
    S_OUT
  } state_e;

  state_e                    state_q;
  logic [CFG_W-1:0]          cfg_q;
  logic [AW-1:0]             idx_q, idx_d;
  logic [RAW_W-1:0]          x_q;
  entry_t                    prev_q;
  logic [RAW_W-1:0]          a_q;
  logic signed [TEMP_W:0]    d_q;
  logic [RAW_W-1:0]          den_q;
  logic [TEMP_W-1:0]         t1_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic                      neg_q;
  logic [TEMP_W-1:0]         temp_q;
  logic [REGION_W-1:0]       region_q;

  logic                      in_acc;
  logic [IW-1:0]             widx;
  logic                      ram_we;
  entry_t                    wentry;
  logic [ENTRY_W-1:0]        rdata;
  entry_t                    cur;
  logic [CW-1:0]             n_ext;
  logic [CW-1:0]             n_use;
  logic [CW-1:0]             n_last;
  logic [AW-1:0]             last_idx;
  logic                      hit;
  logic signed [TEMP_W:0]    d_full;
  logic signed [PROD_W-1:0]  mul_full;
  logic [PROD_W-1:0]         mag_full;
  logic [TEMP_W-1:0]         q_mag;
  logic [TEMP_W-1:0]         q_sgn;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  assign in_acc = in_i.valid && in_i.ready;

  // entry count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // clamp the count into the usable range
  always_comb begin
    n_ext = CW'(cfg_q);
    n_use = n_ext;
    if (n_ext < CW'(2)) begin
      n_use = CW'(2);
    end else if (n_ext > CW'(TABLE_DEPTH)) begin
      n_use = CW'(TABLE_DEPTH);
    end
    n_last   = n_use - CW'(1);
    last_idx = n_last[AW-1:0];
  end

  // table write path, out-of-range positions dropped
  always_comb begin
    widx        = IW'(in_i.entry_index);
    ram_we      = in_acc && (in_i.func == FUNC_WRITE) &&
                  ({1'b0, widx} < (IW + 1)'(TABLE_DEPTH));
    wentry.raw  = in_i.entry_raw;
    wentry.temp = in_i.entry_temp;
  end

  tti_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx[AW-1:0]),
    .wdata_i (wentry),
    .raddr_i (idx_d),
    .rdata_o (rdata)
  );

  assign cur = entry_t'(rdata);

  // segment test against the previous point
  always_comb begin
    hit    = (x_q <= prev_q.raw) && (x_q > cur.raw);
    d_full = $signed({cur.temp[TEMP_W-1], cur.temp}) -
             $signed({prev_q.temp[TEMP_W-1], prev_q.temp});
  end

  // next read address: the RAM output always holds the entry at idx_q
  always_comb begin
    idx_d = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_i.func == FUNC_CONVERT)) begin
          idx_d = '0;
        end
      end
      S_TOP: begin
        if (!(x_q > cur.raw)) begin
          idx_d = last_idx;
        end
      end
      S_BOT: begin
        if (!(x_q <= cur.raw)) begin
          idx_d = AW'(1);
        end
      end
      S_SCAN: begin
        if (!hit && (idx_q != last_idx)) begin
          idx_d = idx_q + AW'(1);
        end
      end
      default: idx_d = idx_q;
    endcase
  end

  // multiply, magnitude and final sign
  always_comb begin
    mul_full = PROD_W'($signed({1'b0, a_q})) * PROD_W'(d_q);
    mag_full = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : prod_q;
    q_mag    = div_rsp.quotient[TEMP_W-1:0];
    q_sgn    = neg_q ? (~q_mag + TEMP_W'(1)) : q_mag;
  end

  always_comb begin
    div_req.start    = (state_q == S_DIVS);
    div_req.dividend = mag_full[MAG_W-1:0];
    div_req.divisor  = den_q;
  end

  tti_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      idx_q <= idx_d;
      case (state_q)
        S_IDLE: begin
          if (in_acc && (in_i.func == FUNC_CONVERT)) begin
            x_q     <= in_i.sample_raw;
            state_q <= S_TOP;
          end
        end
        S_TOP: begin
          if (x_q > cur.raw) begin
            temp_q   <= cur.temp;
            region_q <= REGION_ABOVE;
            state_q  <= S_OUT;
          end else begin
            prev_q  <= cur;
            state_q <= S_BOT;
          end
        end
        S_BOT: begin
          if (x_q <= cur.raw) begin
            temp_q   <= '0;
            region_q <= REGION_BELOW;
            state_q  <= S_OUT;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            a_q     <= prev_q.raw - x_q;
            d_q     <= d_full;
            den_q   <= prev_q.raw - cur.raw;
            t1_q    <= prev_q.temp;
            state_q <= S_MUL;
          end else if (idx_q == last_idx) begin
            temp_q   <= '0;
            region_q <= REGION_BELOW;
            state_q  <= S_OUT;
          end else begin
            prev_q <= cur;
          end
        end
        S_MUL: begin
          prod_q  <= mul_full;
          state_q <= S_DIVS;
        end
        S_DIVS: begin
          neg_q   <= prod_q[PROD_W-1];
          state_q <= S_DIVW;
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            temp_q   <= t1_q + q_sgn;
            region_q <= REGION_INTERP;
            state_q  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = (state_q == S_OUT);
  assign out_o.temperature = temp_q;
  assign out_o.region      = region_q;

endmodule

>>> dv/tti_conversion_checker.sv
`timescale 1ns / 1ps
module tti_conversion_checker import tti_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  tti_in_if                in_i,
  tti_out_if               out_i,
  output int               pending_o,
  output int               mismatches_o
);

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [REGION_W-1:0]      region;
  } reading_t;

  // shadow of the calibration table and the entry count
  logic [RAW_W-1:0]         raw_tab  [TABLE_DEPTH];
  logic signed [TEMP_W-1:0] temp_tab [TABLE_DEPTH];
  logic [CFG_W-1:0]         entry_count;

  reading_t expected_readings [$];
  reading_t want;
  int       mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // temperature the block should give for one reading
  function automatic reading_t convert_reading(input logic [RAW_W-1:0] x);
    reading_t r;
    int       n;
    int       i;
    int       r1, r2, t1, t2;
    bit       found;
    n = int'(entry_count);
    if (n < 2) n = 2;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    found = 1'b0;
    if (x > raw_tab[0]) begin
      r.temperature = temp_tab[0];
      r.region      = REGION_ABOVE;
      return r;
    end
    r.temperature = '0;
    r.region      = REGION_BELOW;
    if (x <= raw_tab[n-1]) return r;
    // first segment that holds the reading
    for (i = 0; i < n - 1; i++) begin
      if (!found && x <= raw_tab[i] && x > raw_tab[i+1]) begin
        r1 = int'(raw_tab[i]);
        r2 = int'(raw_tab[i+1]);
        t1 = int'(temp_tab[i]);
        t2 = int'(temp_tab[i+1]);
        r.temperature = TEMP_W'(t1 + ((int'(x) - r1) * (t2 - t1)) / (r2 - r1));
        r.region      = REGION_INTERP;
        found         = 1'b1;
      end
    end
    return r;
  endfunction

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        raw_tab[i]  <= '0;
        temp_tab[i] <= '0;
      end
      entry_count <= CFG_RESET;
      expected_readings.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) entry_count <= cfg_wdata_i;
      // results first: they always belong to earlier requests
      if (out_i.valid && out_i.ready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("result with no request outstanding (temperature %0d region %0d)",
                                    $signed(out_i.temperature), out_i.region));
        end else begin
          want = expected_readings.pop_front();
          if (out_i.temperature !== want.temperature)
            report_mismatch($sformatf("temperature %0d, expected %0d",
                                      $signed(out_i.temperature), $signed(want.temperature)));
          if (out_i.region !== want.region)
            report_mismatch($sformatf("region %0d, expected %0d", out_i.region, want.region));
        end
      end
      if (in_i.valid && in_i.ready) begin
        if (in_i.func == FUNC_WRITE) begin
          raw_tab[in_i.entry_index]  <= in_i.entry_raw;
          temp_tab[in_i.entry_index] <= in_i.entry_temp;
        end else begin
          expected_readings.push_back(convert_reading(in_i.sample_raw));
        end
      end
      pending_o <= expected_readings.size();
    end
  end

endmodule

>>> dv/tb_thermistor_table_interpolator.sv
`timescale 1ns / 1ps
module tb_thermistor_table_interpolator;
  import tti_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 64;
  localparam int LIMIT_CYCLES  = 500000;
  localparam int PHASES        = 12;
  localparam int READS_PER_PHASE = 26;

  typedef enum logic [1:0] {SINK_EAGER, SINK_RANDOM, SINK_SLUGGISH, SINK_PERIODIC} sink_mode_e;

  // calibration table for the directed part, extremes of temperature at the top
  localparam logic [RAW_W-1:0] CAL_RAW [TABLE_DEPTH] = '{
    12'd4000, 12'd3800, 12'd3500, 12'd3200, 12'd2900, 12'd2600, 12'd2300, 12'd2000,
    12'd1700, 12'd1400, 12'd1100, 12'd800,  12'd500,  12'd300,  12'd100,  12'd0
  };
  localparam logic [TEMP_W-1:0] CAL_TEMP [TABLE_DEPTH] = '{
    16'h8000, 16'h7fff, 16'd900,  16'd800,  16'd650,  16'd500,  16'd350,  16'd200,
    16'd50,   16'hff9c, 16'hff06, 16'hfe70, 16'hfdda, 16'hffff, 16'd0,    16'd1234
  };

  // extremes first, then ordinary counts; later phases pick a count at random
  localparam logic [CFG_W-1:0] COUNT_PLAN [8] = '{
    5'd2, 5'd31, 5'd0, 5'd16, 5'd1, 5'd17, 5'd5, 5'd9
  };

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  tti_in_if  in_if ();
  tti_out_if out_if ();

  int  pending;
  int  mismatches;
  int  cycle_count = 0;
  bit  stall_sink_req = 1'b0;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;

  // what the table holds now, for aiming readings at its points
  logic [RAW_W-1:0] raw_copy [TABLE_DEPTH];
  logic [CFG_W-1:0] count_now = CFG_RESET;

  always #5 clk_i = ~clk_i;

  thermistor_table_interpolator #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  tti_conversion_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_conv_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_i       (out_if),
    .pending_o   (pending),
    .mismatches_o(mismatches)
  );

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_thermistor_table_interpolator failed");
      $finish;
    end
  end

  // one request, held until taken; bursts of back-to-back requests, with gaps between when gaps_on is set
  task automatic offer(input logic f, input logic [IDX_W-1:0] idx, input logic [RAW_W-1:0] raw,
                       input logic [TEMP_W-1:0] temp, input logic [RAW_W-1:0] reading);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) gap = $urandom_range(1, 6);
    end
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.func        = f;
    in_if.entry_index = idx;
    in_if.entry_raw   = raw;
    in_if.entry_temp  = temp;
    in_if.sample_raw  = reading;
    in_if.valid       = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic write_entry(input logic [IDX_W-1:0] idx, input logic [RAW_W-1:0] raw,
                             input logic [TEMP_W-1:0] temp);
    raw_copy[idx] = raw;
    offer(FUNC_WRITE, idx, raw, temp, RAW_W'($urandom));
  endtask

  task automatic convert(input logic [RAW_W-1:0] reading);
    offer(FUNC_CONVERT, IDX_W'($urandom), RAW_W'($urandom), TEMP_W'($urandom), reading);
  endtask

  // register write once the block has gone quiet
  task automatic set_entry_count(input logic [CFG_W-1:0] value);
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    count_now = value;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  // result side: stall pattern of its own, plus one long hold-off on request
  initial begin : result_sink
    sink_mode_e mode;
    int         span;
    int         tick;
    out_if.ready = 1'b0;
    mode = SINK_EAGER;
    span = 0;
    tick = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_sink_req) begin
        stall_sink_req = 1'b0;
        out_if.ready   = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        if (span == 0) begin
          mode = sink_mode_e'($urandom_range(0, 3));
          span = $urandom_range(20, 200);
        end
        span--;
        tick++;
        case (mode)
          SINK_EAGER:    out_if.ready = 1'b1;
          SINK_RANDOM:   out_if.ready = 1'($urandom_range(0, 1));
          SINK_SLUGGISH: out_if.ready = ($urandom_range(0, 5) == 0);
          default:       out_if.ready = ((tick % 7) < 3);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [RAW_W-1:0]  new_raw  [TABLE_DEPTH];
    logic [TEMP_W-1:0] new_temp [TABLE_DEPTH];
    logic [RAW_W-1:0]  reading;
    int                cur, cap, stepmax, t, n, k, idx;
    bit                well_formed, reversed, ramp_temps;

    in_if.valid       = 1'b0;
    in_if.func        = FUNC_WRITE;
    in_if.entry_index = '0;
    in_if.entry_raw   = '0;
    in_if.entry_temp  = '0;
    in_if.sample_raw  = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: full table, then the clamps, exact points and neighbours
    set_entry_count(5'd16);
    for (int i = 0; i < TABLE_DEPTH; i++) write_entry(IDX_W'(i), CAL_RAW[i], CAL_TEMP[i]);
    convert(12'd4095);
    convert(12'd4001);
    convert(12'd4000);
    convert(12'd3999);
    convert(12'd3801);
    convert(12'd3800);
    convert(12'd2450);
    convert(12'd1);
    convert(12'd0);
    // count at and beyond its limits
    set_entry_count(5'd2);
    convert(12'd3900);
    convert(12'd3800);
    set_entry_count(5'd0);
    convert(12'd3850);
    set_entry_count(5'd31);
    convert(12'd50);
    set_entry_count(5'd1);
    convert(12'd4000);

    // random phases: new count, new table, then readings aimed around its points
    for (int p = 0; p < PHASES; p++) begin
      set_entry_count(p < 8 ? COUNT_PLAN[p] : CFG_W'($urandom_range(0, 31)));
      gaps_on = (p % 3 != 0);

      well_formed = ($urandom_range(0, 4) != 0);
      ramp_temps  = 1'($urandom_range(0, 1));
      cur = ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(15, 4095);
      t   = $urandom_range(0, 2000) - 1000;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (well_formed) begin
          // strictly descending, leaving room for the entries still to come
          if (i > 0) begin
            cap     = cur - (TABLE_DEPTH - 1 - i);
            stepmax = ($urandom_range(0, 3) == 0) ? 1 : 2 * cap / (TABLE_DEPTH - i);
            if (stepmax < 1) stepmax = 1;
            if (stepmax > cap) stepmax = cap;
            cur = cur - $urandom_range(1, stepmax);
          end
          new_raw[i] = RAW_W'(cur);
        end else begin
          new_raw[i] = (i > 0 && $urandom_range(0, 3) == 0) ? new_raw[i-1] : RAW_W'($urandom);
        end
        if (ramp_temps) begin
          t = t + $urandom_range(0, 400);
          new_temp[i] = TEMP_W'(t);
        end else begin
          new_temp[i] = TEMP_W'($urandom);
        end
      end
      reversed = 1'($urandom_range(0, 1));
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        idx = reversed ? TABLE_DEPTH - 1 - j : j;
        write_entry(IDX_W'(idx), new_raw[idx], new_temp[idx]);
      end

      // long hold-off on the result side while requests keep coming
      if (p == 1) stall_sink_req = 1'b1;

      for (int r = 0; r < READS_PER_PHASE; r++) begin
        if ($urandom_range(0, 15) == 0)
          write_entry(IDX_W'($urandom), RAW_W'($urandom), TEMP_W'($urandom));
        n = (int'(count_now) < 2) ? 2 :
            ((int'(count_now) > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_now));
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 7))
          0:       reading = raw_copy[k];
          1:       reading = raw_copy[k] + 1'b1;
          2:       reading = raw_copy[k] - 1'b1;
          3, 4:    reading = RAW_W'($urandom_range(raw_copy[0], raw_copy[n-1]));
          5:       reading = $urandom_range(0, 1) ? {RAW_W{1'b1}} : '0;
          default: reading = RAW_W'($urandom);
        endcase
        convert(reading);
      end
    end

    // drain and verdict
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("tb_thermistor_table_interpolator passed");
    end else begin
      $display("tb_thermistor_table_interpolator failed");
    end
    $finish;
  end

endmodule
